[design/chw_pkg.sv]
// Package for the Chebyshev harmonic waveshaper: payload structs, sequencer
// states, datapath controls, fixed-point widths and constants.
// No dependencies.
`default_nettype none

package chw_pkg;

    // Number of harmonics in the gain table (harmonics 1..HARMONICS)
    localparam int HARMONICS = 16;
    localparam int CNT_W     = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;

    // Fixed-point widths: T in Q.30 with headroom, products, accumulator
    localparam int X_W    = 16;
    localparam int G_W    = 16;
    localparam int MA_W   = 17;              // gain or x, with room to negate gain
    localparam int TW     = 34;              // T_n values, Q.30
    localparam int PW     = MA_W + TW;       // product width
    localparam int ACC_W  = PW + CNT_W + 1;  // sum of HARMONICS products
    localparam int OUT_W  = 24;

    localparam int T_SHIFT   = 14;
    localparam int OUT_SHIFT = 27;

    localparam logic signed [TW-1:0]    T_ONE    = TW'(1 << 30);
    localparam logic signed [PW-1:0]    T_RND    = PW'(1 << (T_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] OUT_RND  = ACC_W'(1 << (OUT_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] OUT_MAX  = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] OUT_MIN  = ACC_W'(-8388608);

    // Configuration port
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_BASIS_MODE = '0;

    // Item actions and basis modes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;
    localparam logic MODE_TRIG = 1'b0;
    localparam logic MODE_POLY = 1'b1;

    typedef struct packed {
        logic              action;
        logic [4:0]        harmonic_index;
        logic signed [15:0] gain_value;
        logic signed [15:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] shaped_sample;
        logic                    saturated;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_G,
        ST_FINAL,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_STEP_X,
        DP_STEP_G,
        DP_FINAL,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   negate;
    } dp_ctrl_t;

    typedef struct packed {
        logic                  en;
        logic [CNT_W-1:0]      addr;
        logic signed [G_W-1:0] data;
    } tbl_wr_t;

endpackage

`default_nettype wire

[design/chw_cfg_regs.sv]
// Configuration register block (APB-style), holds basis_mode.
// Depends on chw_pkg.
`default_nettype none

module chw_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [chw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output logic                           basis_mode
);

    logic mode_reg;
    logic mode_next;
    logic wr_fire;
    logic hit;

    assign pready  = 1'b1;
    assign hit     = (paddr[chw_pkg::ADDR_W-1:2] == chw_pkg::REG_BASIS_MODE);
    assign wr_fire = psel & penable & pwrite & pready;

    // Register write
    always_comb
    begin
        mode_next = mode_reg;
        if (wr_fire && hit)
        begin
            mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= chw_pkg::MODE_TRIG;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = {31'd0, mode_reg};
        end
    end

    assign basis_mode = mode_reg;

endmodule

`default_nettype wire

[design/chw_gain_table.sv]
// Harmonic gain table: one write port, one read port, all gains reset to zero.
// Depends on chw_pkg.
`default_nettype none

module chw_gain_table (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire chw_pkg::tbl_wr_t               wr,
    input  wire logic [chw_pkg::CNT_W-1:0]      rd_addr,
    output logic signed [chw_pkg::G_W-1:0]      rd_gain
);

    logic signed [chw_pkg::G_W-1:0] gain_reg [chw_pkg::HARMONICS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < chw_pkg::HARMONICS; i++)
            begin
                gain_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            gain_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_gain = gain_reg[rd_addr];

endmodule

`default_nettype wire

[design/chw_datapath.sv]
// Shared-multiplier datapath: Chebyshev recurrence, gain products,
// accumulator, final rounding and saturation into the result register.
// Depends on chw_pkg.
`default_nettype none

module chw_datapath (
    input  wire logic                           clk,
    input  wire chw_pkg::dp_ctrl_t              ctrl,
    input  wire logic signed [chw_pkg::X_W-1:0] sample,
    input  wire logic signed [chw_pkg::G_W-1:0] gain,
    output chw_pkg::out_t                       result
);

    localparam int TW    = chw_pkg::TW;
    localparam int PW    = chw_pkg::PW;
    localparam int ACC_W = chw_pkg::ACC_W;
    localparam int MA_W  = chw_pkg::MA_W;

    logic signed [chw_pkg::X_W-1:0] x_reg;
    logic signed [TW-1:0]           t_prev_reg;
    logic signed [TW-1:0]           t_cur_reg;
    logic signed [PW-1:0]           prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    chw_pkg::out_t                  result_reg;

    logic signed [MA_W-1:0]  mul_a;
    logic signed [TW-1:0]    mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [PW-1:0]    rnd_sum;
    logic signed [PW-1:0]    rnd_shift;
    logic signed [TW-1:0]    t_next;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] out_sum;
    logic signed [ACC_W-1:0] out_rnd;
    chw_pkg::out_t           result_next;

    // Shared multiplier: gain times T_n in the gain step, x times T_n otherwise.
    // Sign of the trig basis is folded into the gain operand.
    always_comb
    begin
        if (ctrl.op == chw_pkg::DP_STEP_G)
        begin
            mul_a = ctrl.negate ? -MA_W'(gain) : MA_W'(gain);
        end
        else
        begin
            mul_a = MA_W'(x_reg);
        end
        mul_b = t_cur_reg;
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // Recurrence: T_{n+1} = rnd(x * T_n / 2^14) - T_{n-1}
    always_comb
    begin
        rnd_sum   = prod_reg + chw_pkg::T_RND;
        rnd_shift = rnd_sum >>> chw_pkg::T_SHIFT;
        t_next    = $signed(rnd_shift[TW-1:0]) - t_prev_reg;
        acc_sum   = acc_reg + ACC_W'(prod_reg);
    end

    // Round half up to Q.17 and saturate
    always_comb
    begin
        out_sum = acc_reg + chw_pkg::OUT_RND;
        out_rnd = out_sum >>> chw_pkg::OUT_SHIFT;
        result_next.saturated = 1'b0;
        result_next.shaped_sample = out_rnd[chw_pkg::OUT_W-1:0];
        if (out_rnd > chw_pkg::OUT_MAX)
        begin
            result_next.saturated     = 1'b1;
            result_next.shaped_sample = chw_pkg::OUT_MAX[chw_pkg::OUT_W-1:0];
        end
        else if (out_rnd < chw_pkg::OUT_MIN)
        begin
            result_next.saturated     = 1'b1;
            result_next.shaped_sample = chw_pkg::OUT_MIN[chw_pkg::OUT_W-1:0];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            chw_pkg::DP_LOAD:
            begin
                x_reg      <= sample;
                t_prev_reg <= chw_pkg::T_ONE;
                t_cur_reg  <= TW'(sample) <<< 15;
                prod_reg   <= '0;
                acc_reg    <= '0;
            end
            chw_pkg::DP_STEP_X:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_sum;
            end
            chw_pkg::DP_STEP_G:
            begin
                prod_reg   <= mul_p;
                t_prev_reg <= t_cur_reg;
                t_cur_reg  <= t_next;
            end
            chw_pkg::DP_FINAL:
            begin
                acc_reg <= acc_sum;
            end
            chw_pkg::DP_EMIT:
            begin
                result_reg <= result_next;
            end
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[design/chw_sequencer.sv]
// Sequencer: input/output handshakes, harmonic counter, gain table writes,
// and per-cycle control of the shared datapath.
// Depends on chw_pkg.
`default_nettype none

module chw_sequencer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    input  wire chw_pkg::in_t              item,
    input  wire logic                      result_ready,
    input  wire logic                      basis_mode,
    output logic                           item_ready,
    output logic                           result_valid,
    output chw_pkg::dp_ctrl_t              ctrl,
    output chw_pkg::tbl_wr_t               tbl_wr,
    output logic [chw_pkg::CNT_W-1:0]      rd_addr
);

    localparam int CNT_W = chw_pkg::CNT_W;

    chw_pkg::state_t  state_reg;
    chw_pkg::state_t  state_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [1:0]       mod4_reg;
    logic [1:0]       mod4_next;
    logic             valid_reg;
    logic             valid_next;

    logic item_fire;
    logic emit_fire;
    logic last_n;
    logic idx_ok;

    assign item_fire = item_valid && item_ready;
    assign emit_fire = (state_reg == chw_pkg::ST_EMIT) && (!valid_reg || result_ready);
    assign last_n    = (n_reg == CNT_W'(chw_pkg::HARMONICS - 1));
    assign idx_ok    = (item.harmonic_index != 5'd0)
                    && (7'(item.harmonic_index) <= 7'(chw_pkg::HARMONICS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chw_pkg::ST_IDLE:
            begin
                if (item_fire && item.action == chw_pkg::ACT_EVAL)
                begin
                    state_next = chw_pkg::ST_MUL_X;
                end
            end
            chw_pkg::ST_MUL_X:
            begin
                state_next = chw_pkg::ST_MUL_G;
            end
            chw_pkg::ST_MUL_G:
            begin
                state_next = last_n ? chw_pkg::ST_FINAL : chw_pkg::ST_MUL_X;
            end
            chw_pkg::ST_FINAL:
            begin
                state_next = chw_pkg::ST_EMIT;
            end
            chw_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = chw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chw_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and counters
    always_comb
    begin
        item_ready  = (state_reg == chw_pkg::ST_IDLE);
        ctrl.op     = chw_pkg::DP_HOLD;
        ctrl.negate = (basis_mode == chw_pkg::MODE_TRIG) && (mod4_reg == 2'd3);
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = CNT_W'(item.harmonic_index - 5'd1);
        tbl_wr.data = item.gain_value;
        n_next      = n_reg;
        mod4_next   = mod4_reg;
        case (state_reg)
            chw_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (item.action == chw_pkg::ACT_EVAL)
                    begin
                        ctrl.op   = chw_pkg::DP_LOAD;
                        n_next    = '0;
                        mod4_next = 2'd1;
                    end
                    else
                    begin
                        tbl_wr.en = idx_ok;
                    end
                end
            end
            chw_pkg::ST_MUL_X:
            begin
                ctrl.op = chw_pkg::DP_STEP_X;
            end
            chw_pkg::ST_MUL_G:
            begin
                ctrl.op   = chw_pkg::DP_STEP_G;
                mod4_next = mod4_reg + 2'd1;
                if (!last_n)
                begin
                    n_next = n_reg + CNT_W'(1);
                end
            end
            chw_pkg::ST_FINAL:
            begin
                ctrl.op = chw_pkg::DP_FINAL;
            end
            chw_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    ctrl.op = chw_pkg::DP_EMIT;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (emit_fire)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chw_pkg::ST_IDLE;
            n_reg     <= '0;
            mod4_reg  <= 2'd1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            mod4_reg  <= mod4_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign rd_addr      = n_reg;

endmodule

`default_nettype wire

[design/chebyshev_harmonic_waveshaper.sv]
// Chebyshev harmonic waveshaper, top level.
// Depends on chw_pkg, chw_cfg_regs, chw_gain_table, chw_sequencer, chw_datapath.
//
// Usage:
//   item channel (item_valid/item_ready/item): a write transaction (action 0)
//   stores one harmonic gain, harmonic 1..HARMONICS, others are dropped; an
//   evaluate transaction (action 1) takes one Q1.15 sample.
//   result channel (result_valid/result_ready/result): one Q7.17 transaction
//   per evaluate, with a flag when the sum was clipped.
//   APB port: register 0 at byte address 0 is basis_mode (0 trig, 1 poly).
// Timing:
//   A write leaves item_ready high.
//   An evaluate, once accepted, computes two products per harmonic on the one
//   shared 17x34 multiplier, then an accumulate step and a round/saturate step
//   that registers the result. A new item is taken only once the block is back
//   in idle, so no item is accepted while an evaluate is in progress.
//   If the receiver stalls, the result holds in its output register; the
//   next item is still accepted and computed, waiting only before its own
//   result is written.
// Reset: all gains zero, basis_mode 0, no result pending.
`default_nettype none

module chebyshev_harmonic_waveshaper (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire chw_pkg::in_t              item,
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output chw_pkg::out_t                  result,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [chw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready
);

    logic                            basis_mode;
    chw_pkg::dp_ctrl_t               ctrl;
    chw_pkg::tbl_wr_t                tbl_wr;
    logic [chw_pkg::CNT_W-1:0]       rd_addr;
    logic signed [chw_pkg::G_W-1:0]  rd_gain;

    chw_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .basis_mode (basis_mode)
    );

    chw_gain_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_gain (rd_gain)
    );

    chw_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .result_ready (result_ready),
        .basis_mode   (basis_mode),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .ctrl         (ctrl),
        .tbl_wr       (tbl_wr),
        .rd_addr      (rd_addr)
    );

    chw_datapath u_dp (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (item.sample),
        .gain   (rd_gain),
        .result (result)
    );

endmodule

`default_nettype wire

[design/chw_checker.sv]
// Port-level checker for the waveshaper, bound to the top level.
// Depends on chw_pkg and chebyshev_harmonic_waveshaper.
`default_nettype none

module chw_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          item_valid,
    input wire logic          item_ready,
    input wire chw_pkg::in_t  item,
    input wire logic          result_valid,
    input wire logic          result_ready,
    input wire chw_pkg::out_t result
);

    // Stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // An evaluate makes the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.action == chw_pkg::ACT_EVAL |=> !item_ready)
        else $error("item_ready high right after evaluate");

    // A write leaves the block ready
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.action == chw_pkg::ACT_WRITE |=> item_ready)
        else $error("item_ready dropped after write");

    // A new result only follows a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared without computation");

    // Saturation flag means the value sits at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            result.shaped_sample == 24'sh7FFFFF || result.shaped_sample == 24'sh800000)
        else $error("saturated flag without rail value");

endmodule

bind chebyshev_harmonic_waveshaper chw_checker u_chw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[test/chw_shaper_tb_pkg.sv]
// Scoreboard for the Chebyshev harmonic waveshaper testbench: a bit-exact
// predictor of the harmonic sum plus the queue of expected results.
// Depends on chw_pkg for the payload structs, modes and HARMONICS.
package chw_shaper_tb_pkg;

    import chw_pkg::*;

    localparam longint SHAPED_MAX  = 64'sd8388607;
    localparam longint SHAPED_MIN  = -64'sd8388608;

    class shaper_scoreboard;
        logic signed [15:0] gains [1:HARMONICS];
        logic               basis;
        out_t               shaped_q [$];
        int                 errors;

        function new();
            foreach (gains[i])
                gains[i] = '0;
            basis  = MODE_TRIG;
            errors = 0;
        endfunction

        function void set_basis(logic mode);
            basis = mode;
        endfunction

        function int outstanding();
            return shaped_q.size();
        endfunction

        // Weighted sum of T_n(x), T values in Q.30, products summed exactly
        function out_t shape_sample(logic signed [15:0] s);
            longint x;
            longint t_prev;
            longint t_cur;
            longint t_next;
            longint term;
            longint acc;
            longint sum;
            int     n;
            out_t   r;
            x      = s;
            t_prev = 64'sd1 <<< 30;
            t_cur  = x * 64'sd32768;
            acc    = 0;
            for (n = 1; n <= HARMONICS; n++)
            begin
                term = t_cur;
                // trig basis: sin(n*asin x) flips sign on n mod 4 == 3
                if (basis == MODE_TRIG && (n % 4) == 3)
                    term = -term;
                acc += longint'(gains[n]) * term;
                t_next = ((x * t_cur + (64'sd1 <<< 13)) >>> 14) - t_prev;
                t_prev = t_cur;
                t_cur  = t_next;
            end
            sum         = (acc + (64'sd1 <<< 26)) >>> 27;
            r.saturated = 1'b0;
            if (sum > SHAPED_MAX)
            begin
                sum         = SHAPED_MAX;
                r.saturated = 1'b1;
            end
            else if (sum < SHAPED_MIN)
            begin
                sum         = SHAPED_MIN;
                r.saturated = 1'b1;
            end
            r.shaped_sample = sum[23:0];
            return r;
        endfunction

        // Accepted input transaction: update the gain table or queue a result
        function void note_item(in_t it);
            if (it.action == ACT_WRITE)
            begin
                // harmonic zero and indexes past the table are dropped
                if (it.harmonic_index >= 1 && it.harmonic_index <= HARMONICS)
                    gains[it.harmonic_index] = it.gain_value;
            end
            else
                shaped_q.push_back(shape_sample(it.sample));
        endfunction

        // Accepted result transaction: compare with the oldest expectation
        function void check_result(out_t got);
            out_t exp_r;
            if (shaped_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got shaped_sample %0d saturated %0b",
                         $time, got.shaped_sample, got.saturated);
                return;
            end
            exp_r = shaped_q.pop_front();
            if (got.shaped_sample !== exp_r.shaped_sample || got.saturated !== exp_r.saturated)
            begin
                errors++;
                $display("%0t: mismatch, expected shaped_sample %0d saturated %0b, got %0d %0b",
                         $time, exp_r.shaped_sample, exp_r.saturated,
                         got.shaped_sample, got.saturated);
            end
        endfunction
    endclass

endpackage

[test/chebyshev_harmonic_waveshaper_test.sv]
// Testbench for chebyshev_harmonic_waveshaper: directed and random gain writes
// and evaluations in both basis modes, with random stalls on both channels.
// Depends on chw_pkg, chw_shaper_tb_pkg and the waveshaper RTL.
module chebyshev_harmonic_waveshaper_test;

    timeunit 1ns;
    timeprecision 1ps;

    import chw_pkg::*;
    import chw_shaper_tb_pkg::*;

    localparam int                STALL_LIMIT  = 2000;
    localparam int                DRAIN_CYCLES = 2 * HARMONICS + 8;
    localparam int                LONG_HOLD    = 300;
    localparam logic [ADDR_W-1:0] BASIS_ADDR   = {REG_BASIS_MODE, 2'b00};

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    in_t               item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    out_t              result;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;

    bit                quiet        = 1'b0;
    bit                long_hold_req = 1'b0;
    int                stall_cycles = 0;

    shaper_scoreboard  sb = new();

    chebyshev_harmonic_waveshaper DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result receiver: random stall bursts, ready stretches, one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 15) < 3)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(0, 39)) @(negedge clk);
            end
        end
    end

    function automatic in_t make_write(int unsigned idx, logic signed [15:0] g);
        in_t it;
        it                = '0;
        it.action         = ACT_WRITE;
        it.harmonic_index = idx[4:0];
        it.gain_value     = g;
        return it;
    endfunction

    function automatic in_t make_eval(logic signed [15:0] x);
        in_t it;
        it        = '0;
        it.action = ACT_EVAL;
        it.sample = x;
        return it;
    endfunction

    // 16-bit value weighted toward the extremes
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t random_item();
        in_t it;
        it = in_t'({$urandom, $urandom});
        if ($urandom_range(0, 99) < 40)
        begin
            it.action = ACT_WRITE;
            // mostly valid harmonics, some dropped indexes
            if ($urandom_range(0, 99) < 85)
                it.harmonic_index = 5'($urandom_range(1, HARMONICS));
            else
                it.harmonic_index = ($urandom_range(0, 3) == 0) ? 5'd0
                                    : 5'($urandom_range(HARMONICS + 1, 31));
            it.gain_value = pick16();
        end
        else
        begin
            it.action = ACT_EVAL;
            it.sample = pick16();
        end
        return it;
    endfunction

    // Offer one input transaction, then maybe idle for a burst
    task automatic send_item(in_t it);
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
    endtask

    // Stop offering, wait for all results, then let the datapath settle
    task automatic wait_for_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of basis_mode on an idle block, then read it back
    task automatic set_basis_mode(logic mode);
        wait_for_drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASIS_ADDR;
        pwdata  <= 32'(mode);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_basis(mode);
        @(negedge clk);
        psel    <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== mode)
        begin
            sb.errors++;
            $display("%0t: basis_mode readback expected %0b, got %0b", $time, mode, prdata[0]);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_run(int count, int quiet_tail);
        for (int i = 0; i < count; i++)
        begin
            if (count - i <= quiet_tail)
                quiet = 1'b1;
            send_item(random_item());
        end
    endtask

    // Main stimulus
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, polynomial basis: gain extremes, dropped indexes, sample extremes
        set_basis_mode(MODE_POLY);
        send_item(make_eval(16'sh4000));          // all gains still zero
        send_item(make_write(1, 16'sh7FFF));
        send_item(make_write(HARMONICS, 16'sh8000));
        send_item(make_write(3, 16'sh4000));      // sign-flipped harmonic in trig mode
        send_item(make_write(7, -16'sh4000));
        send_item(make_write(2, 16'sh2000));
        send_item(make_write(0, 16'sh1234));      // no DC term
        send_item(make_write(HARMONICS + 1, 16'sh7FFF));
        send_item(make_write(31, 16'sh8000));
        send_item(make_eval(16'sh8000));
        send_item(make_eval(16'sh7FFF));
        send_item(make_eval(16'sh0000));
        send_item(make_eval(16'shFFFF));
        send_item(make_eval(16'sh4000));

        // Directed, trig basis: same samples
        set_basis_mode(MODE_TRIG);
        send_item(make_eval(16'sh8000));
        send_item(make_eval(16'sh7FFF));
        send_item(make_eval(16'sh0000));
        send_item(make_eval(16'shFFFF));
        send_item(make_eval(16'sh4000));

        // Random, trig basis
        random_run(430, 0);

        // Random, polynomial basis, starting with a long receiver hold-off
        set_basis_mode(MODE_POLY);
        long_hold_req = 1'b1;
        random_run(430, 0);

        // Random, trig basis, sender pause midway, no idling at the end
        set_basis_mode(MODE_TRIG);
        random_run(220, 0);
        wait_for_drain();
        random_run(220, 150);

        wait_for_drain();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
